[rtl/ssa_pkg.sv]
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants of the swap slot allocator: opcodes, status
// codes, slot states, slot table entry and the free-map search result.
// ----------------------------------------------------------------------------
package ssa_pkg;

  // default table size
  localparam int unsigned SLOT_COUNT_DEF = 1024;

  // free map word geometry
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned WORD_LSB  = 5;

  // configuration reset values
  localparam logic [31:0] CAP_RESET   = 32'd409600;
  localparam logic        STATS_RESET = 1'b1;

  // configuration register indexes
  typedef enum logic {
    CFG_CAPACITY = 1'b0,
    CFG_STATS    = 1'b1
  } cfg_idx_e;

  // item opcodes
  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_MARK   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_RANGE   = 3'd3,
    ST_MISS    = 3'd4
  } status_e;

  // slot states
  typedef enum logic [1:0] {
    SLOT_FREE = 2'd0,
    SLOT_USED = 2'd1,
    SLOT_BAD  = 2'd2
  } slot_state_e;

  // one slot table entry
  typedef struct packed {
    slot_state_e state;
    logic [31:0] access;
  } slot_entry_t;

  // lowest set bit of a free map word
  typedef struct packed {
    logic                found;
    logic [WORD_LSB-1:0] bit_idx;
  } find_t;

endpackage

[rtl/ssa_slot_mem.sv]
// ----------------------------------------------------------------------------
// ssa_slot_mem
// Slot table memory: state and access count of every slot, one write port
// and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssa_slot_mem
  import ssa_pkg::*;
#(
  parameter int unsigned DEPTH = SLOT_COUNT_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic        clk_i,
  input  logic        rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic        wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  slot_entry_t wr_data_i,
  output slot_entry_t rd_data_o
);

  slot_entry_t mem [DEPTH];
  slot_entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/ssa_free_map.sv]
// ----------------------------------------------------------------------------
// ssa_free_map
// Free slot bitmap, one bit per slot packed into words, with registered
// read data and a lowest-free-bit search over the word just read.
// ----------------------------------------------------------------------------
module ssa_free_map
  import ssa_pkg::*;
#(
  parameter int unsigned DEPTH = (SLOT_COUNT_DEF + WORD_BITS - 1) / WORD_BITS,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [WORD_BITS-1:0] wr_data_i,
  output logic [WORD_BITS-1:0] rd_data_o,
  output find_t                find_o
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // priority search for the lowest free bit
  always_comb begin
    find_o.found   = |rd_data_q;
    find_o.bit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (rd_data_q[i]) begin
        find_o.bit_idx = WORD_LSB'(i);
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/swap_slot_allocator_top.sv]
// ----------------------------------------------------------------------------
// swap_slot_allocator_top
// First-fit slot allocator: allocate, lookup and mark over a slot table
// held in memory, with a free bitmap and a search hint for allocation.
//
//   channel   handshake                       payload
//   item      start / busy                    opcode, byte_count, slot, state
//   result    result_valid_o (one cycle)      status, slot, hits, counters
//   config    cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// Lookup and mark read the memory, then modify and write back.
// Allocate reads bitmap words from the search hint on, skipping all-used
// ones, until a free bit turns up; rejects that need no memory are answered
// from the idle state. After reset a clearing pass over every slot holds
// busy high while the slot table and bitmap are set to free; config writes
// wait until the block is idle with no item offered.
// Results cannot be stalled; each one shows for exactly one cycle.
// ----------------------------------------------------------------------------
module swap_slot_allocator_top
  import ssa_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = SLOT_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] byte_count_i,
  input  logic [15:0] slot_number_i,
  input  logic [1:0]  new_state_i,
  // result channel
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [9:0]  granted_slot_o,
  output logic [31:0] slot_hits_o,
  output logic [31:0] bytes_in_use_o,
  output logic [31:0] write_total_o,
  output logic [31:0] read_total_o,
  output logic [31:0] miss_total_o,
  output logic [31:0] pages_in_use_o,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned NUM_WORDS = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned SLOT_AW   = $clog2(NUM_SLOTS);
  localparam int unsigned WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned HINT_W    = $clog2(NUM_WORDS + 1);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_LOOKUP = 5'b01000,
    S_MARK   = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [SLOT_AW-1:0] clr_q, clr_d;
  logic [HINT_W-1:0]  hint_q, hint_d;

  // latched item
  logic [31:0]        bytes_q, bytes_d;
  logic [SLOT_AW-1:0] slot_q, slot_d;
  slot_state_e        nstate_q, nstate_d;

  // configuration
  logic [31:0] cap_q;
  logic        stats_q;

  // counters
  logic [31:0] used_q, used_d;
  logic [31:0] wr_cnt_q, wr_cnt_d;
  logic [31:0] rd_cnt_q, rd_cnt_d;
  logic [31:0] miss_cnt_q, miss_cnt_d;
  logic [31:0] page_cnt_q, page_cnt_d;

  // result registers
  logic        done_q, done_d;
  status_e     status_q, status_d;
  logic [9:0]  granted_q, granted_d;
  logic [31:0] hits_q, hits_d;

  // memory ports
  logic               slot_rd_en, slot_wr_en;
  logic [SLOT_AW-1:0] slot_rd_addr, slot_wr_addr;
  slot_entry_t        slot_wr_data, slot_rd_data;
  logic               map_rd_en, map_wr_en;
  logic [WORD_AW-1:0] map_rd_addr, map_wr_addr;
  logic [WORD_BITS-1:0] map_wr_data, map_rd_data;
  find_t              map_find;

  // helpers
  logic [WORD_BITS-1:0] clr_mask;
  logic                 slot_in_range;
  logic                 no_room;
  logic [15:0]          slot_in_ext, slot_q_ext, alloc_slot;
  logic [WORD_AW-1:0]   slot_q_word;
  logic [WORD_BITS-1:0] slot_q_bit;
  logic [31:0]          acc_inc;

  ssa_slot_mem #(
    .DEPTH(NUM_SLOTS)
  ) u_slot_mem (
    .clk_i    (clk_i),
    .rd_en_i  (slot_rd_en),
    .rd_addr_i(slot_rd_addr),
    .wr_en_i  (slot_wr_en),
    .wr_addr_i(slot_wr_addr),
    .wr_data_i(slot_wr_data),
    .rd_data_o(slot_rd_data)
  );

  ssa_free_map #(
    .DEPTH(NUM_WORDS)
  ) u_free_map (
    .clk_i    (clk_i),
    .rd_en_i  (map_rd_en),
    .rd_addr_i(map_rd_addr),
    .wr_en_i  (map_wr_en),
    .wr_addr_i(map_wr_addr),
    .wr_data_i(map_wr_data),
    .rd_data_o(map_rd_data),
    .find_o   (map_find)
  );

  // initial free mask of the word being cleared: only slots that exist
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      clr_mask[b] = ((32'(clr_q) << WORD_LSB) + 32'(b)) < 32'(NUM_SLOTS);
    end
  end

  // item decode helpers
  assign slot_in_range = {1'b0, slot_number_i} < 17'(NUM_SLOTS);
  assign no_room       = (cap_q < used_q) || ((cap_q - used_q) < byte_count_i);
  assign slot_in_ext   = slot_number_i;
  assign slot_q_ext    = 16'(slot_q);
  assign slot_q_word   = slot_q_ext[WORD_LSB +: WORD_AW];
  assign slot_q_bit    = WORD_BITS'(1) << slot_q_ext[WORD_LSB-1:0];
  assign alloc_slot    = 16'({hint_q[WORD_AW-1:0], map_find.bit_idx});
  assign acc_inc       = slot_rd_data.access + 32'd1;

  // sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    hint_d       = hint_q;
    bytes_d      = bytes_q;
    slot_d       = slot_q;
    nstate_d     = nstate_q;
    used_d       = used_q;
    wr_cnt_d     = wr_cnt_q;
    rd_cnt_d     = rd_cnt_q;
    miss_cnt_d   = miss_cnt_q;
    page_cnt_d   = page_cnt_q;
    done_d       = 1'b0;
    status_d     = status_q;
    granted_d    = granted_q;
    hits_d       = hits_q;
    slot_rd_en   = 1'b0;
    slot_rd_addr = slot_number_i[SLOT_AW-1:0];
    slot_wr_en   = 1'b0;
    slot_wr_addr = slot_q;
    slot_wr_data = '{state: SLOT_FREE, access: '0};
    map_rd_en    = 1'b0;
    map_rd_addr  = hint_q[WORD_AW-1:0];
    map_wr_en    = 1'b0;
    map_wr_addr  = slot_q_word;
    map_wr_data  = '0;

    case (state_q)
      // sweep the slot table and bitmap to free after reset
      S_CLEAR: begin
        slot_wr_en   = 1'b1;
        slot_wr_addr = clr_q;
        if (32'(clr_q) < 32'(NUM_WORDS)) begin
          map_wr_en   = 1'b1;
          map_wr_addr = clr_q[WORD_AW-1:0];
          map_wr_data = clr_mask;
        end
        if (clr_q == SLOT_AW'(NUM_SLOTS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + SLOT_AW'(1);
        end
      end

      // accept an item, answer rejects and no-ops at once, else start the memory read
      S_IDLE: begin
        if (start) begin
          bytes_d   = byte_count_i;
          slot_d    = slot_number_i[SLOT_AW-1:0];
          nstate_d  = slot_state_e'(new_state_i);
          granted_d = '0;
          hits_d    = '0;
          case (op_e'(opcode_i))
            OP_ALLOC: begin
              if (byte_count_i == '0) begin
                done_d   = 1'b1;
                status_d = ST_INVALID;
              end else if (no_room || (hint_q == HINT_W'(NUM_WORDS))) begin
                done_d   = 1'b1;
                status_d = ST_NOSPACE;
              end else begin
                map_rd_en = 1'b1;
                state_d   = S_SCAN;
              end
            end
            OP_LOOKUP: begin
              if (!slot_in_range) begin
                done_d   = 1'b1;
                status_d = ST_RANGE;
              end else begin
                slot_rd_en = 1'b1;
                state_d    = S_LOOKUP;
              end
            end
            OP_MARK: begin
              if (!slot_in_range) begin
                done_d   = 1'b1;
                status_d = ST_RANGE;
              end else if (new_state_i > SLOT_BAD) begin
                done_d   = 1'b1;
                status_d = ST_INVALID;
              end else begin
                slot_rd_en  = 1'b1;
                map_rd_en   = 1'b1;
                map_rd_addr = slot_in_ext[WORD_LSB +: WORD_AW];
                state_d     = S_MARK;
              end
            end
            default: begin
              done_d   = 1'b1;
              status_d = ST_OK;
            end
          endcase
        end
      end

      // walk bitmap words from the hint until a free bit turns up or the last word is done
      S_SCAN: begin
        if (map_find.found) begin
          map_wr_en    = 1'b1;
          map_wr_addr  = hint_q[WORD_AW-1:0];
          map_wr_data  = map_rd_data & ~(WORD_BITS'(1) << map_find.bit_idx);
          slot_wr_en   = 1'b1;
          slot_wr_addr = alloc_slot[SLOT_AW-1:0];
          slot_wr_data = '{state: SLOT_USED, access: '0};
          used_d       = used_q + bytes_q;
          if (stats_q) begin
            wr_cnt_d   = wr_cnt_q + 32'd1;
            page_cnt_d = page_cnt_q + 32'd1;
          end
          done_d    = 1'b1;
          status_d  = ST_OK;
          granted_d = alloc_slot[9:0];
          state_d   = S_IDLE;
        end else if (hint_q == HINT_W'(NUM_WORDS - 1)) begin
          hint_d   = HINT_W'(NUM_WORDS);
          done_d   = 1'b1;
          status_d = ST_NOSPACE;
          state_d  = S_IDLE;
        end else begin
          hint_d      = hint_q + HINT_W'(1);
          map_rd_en   = 1'b1;
          map_rd_addr = hint_d[WORD_AW-1:0];
        end
      end

      // hit bumps the access count, anything else is a miss
      S_LOOKUP: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (slot_rd_data.state == SLOT_USED) begin
          slot_wr_en   = 1'b1;
          slot_wr_data = '{state: SLOT_USED, access: acc_inc};
          hits_d       = acc_inc;
          status_d     = ST_OK;
          if (stats_q) begin
            rd_cnt_d = rd_cnt_q + 32'd1;
          end
        end else begin
          status_d = ST_MISS;
          if (stats_q) begin
            miss_cnt_d = miss_cnt_q + 32'd1;
          end
        end
      end

      // write the new state, keep the access count, fix bitmap and hint
      S_MARK: begin
        slot_wr_en   = 1'b1;
        slot_wr_data = '{state: nstate_q, access: slot_rd_data.access};
        map_wr_en    = 1'b1;
        if (nstate_q == SLOT_FREE) begin
          map_wr_data = map_rd_data | slot_q_bit;
          if (HINT_W'(slot_q_word) < hint_q) begin
            hint_d = HINT_W'(slot_q_word);
          end
        end else begin
          map_wr_data = map_rd_data & ~slot_q_bit;
        end
        done_d   = 1'b1;
        status_d = ST_OK;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      hint_q     <= '0;
      used_q     <= '0;
      wr_cnt_q   <= '0;
      rd_cnt_q   <= '0;
      miss_cnt_q <= '0;
      page_cnt_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      hint_q     <= hint_d;
      used_q     <= used_d;
      wr_cnt_q   <= wr_cnt_d;
      rd_cnt_q   <= rd_cnt_d;
      miss_cnt_q <= miss_cnt_d;
      page_cnt_q <= page_cnt_d;
      done_q     <= done_d;
    end
  end

  // item and result payload registers
  always_ff @(posedge clk_i) begin
    bytes_q   <= bytes_d;
    slot_q    <= slot_d;
    nstate_q  <= nstate_d;
    status_q  <= status_d;
    granted_q <= granted_d;
    hits_q    <= hits_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      stats_q <= STATS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CAPACITY: cap_q   <= cfg_data_i;
        CFG_STATS:    stats_q <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  // ports
  assign busy           = (state_q != S_IDLE);
  assign cfg_ready_o    = (state_q == S_IDLE) && !start;
  assign result_valid_o = done_q;
  assign status_o       = status_q;
  assign granted_slot_o = granted_q;
  assign slot_hits_o    = hits_q;
  assign bytes_in_use_o = used_q;
  assign write_total_o  = wr_cnt_q;
  assign read_total_o   = rd_cnt_q;
  assign miss_total_o   = miss_cnt_q;
  assign pages_in_use_o = page_cnt_q;

  // write and page counters always advance together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_cnt_q == page_cnt_q)
    else $error("write and page counters diverged");

  // search hint never points past the bitmap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q <= HINT_W'(NUM_WORDS))
    else $error("search hint out of range");

  // no table write while waiting for an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!slot_wr_en && !map_wr_en))
    else $error("memory write while idle");

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the swap slot allocator. A short table of directed
// requests (reset values, field extremes, every status code) is followed by
// random request phases under several capacity and stats settings, one of
// them driving the table until no slot is left. A local model of the slot
// table predicts every result, and each result is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import ssa_pkg::*;

  localparam int unsigned NUM_SLOTS = SLOT_COUNT_DEF;
  localparam int unsigned LIMIT_CYCLES = 800000;
  localparam int DIR_N = 20;

  // one expected result
  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  granted;
    logic [31:0] hits;
    logic [31:0] bytes_used;
    logic [31:0] writes;
    logic [31:0] reads;
    logic [31:0] misses;
    logic [31:0] pages;
  } outcome_t;

  // one directed request, with typed status and slot where obvious
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] nbytes;
    logic [15:0] slot;
    logic [1:0]  nst;
    logic        typed;
    logic [2:0]  t_status;
    logic [9:0]  t_granted;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode_i = '0;
  logic [31:0] byte_count_i = '0;
  logic [15:0] slot_number_i = '0;
  logic [1:0]  new_state_i = '0;
  logic        result_valid_o;
  logic [2:0]  status_o;
  logic [9:0]  granted_slot_o;
  logic [31:0] slot_hits_o;
  logic [31:0] bytes_in_use_o;
  logic [31:0] write_total_o;
  logic [31:0] read_total_o;
  logic [31:0] miss_total_o;
  logic [31:0] pages_in_use_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  // model of the slot table and counters
  slot_state_e tab_state [NUM_SLOTS];
  logic [31:0] tab_hits [NUM_SLOTS];
  logic [31:0] cap_reg;
  logic        stats_on;
  logic [31:0] used_bytes;
  logic [31:0] write_cnt;
  logic [31:0] read_cnt;
  logic [31:0] miss_cnt;
  logic [31:0] page_cnt;
  int unsigned hi_slot;

  outcome_t expected_q [$];
  outcome_t want;
  int unsigned fails = 0;
  int unsigned cycle_count = 0;
  int unsigned sent = 0;
  bit          no_idle = 1'b0;

  // directed requests, in order after reset
  dir_row_t dir_rows [DIR_N] = '{
    '{OP_LOOKUP, 32'd0,          16'd0,      2'd0, 1'b1, ST_MISS,    10'd0},
    '{OP_ALLOC,  32'd0,          16'd0,      2'd0, 1'b1, ST_INVALID, 10'd0},
    '{OP_ALLOC,  32'd1,          16'd0,      2'd0, 1'b1, ST_OK,      10'd0},
    '{OP_ALLOC,  32'hFFFF_FFFF,  16'd0,      2'd0, 1'b1, ST_NOSPACE, 10'd0},
    '{OP_LOOKUP, 32'd0,          16'd0,      2'd0, 1'b1, ST_OK,      10'd0},
    '{OP_LOOKUP, 32'd0,          16'd0,      2'd0, 1'b0, ST_OK,      10'd0},
    '{OP_LOOKUP, 32'd0,          16'd1023,   2'd0, 1'b1, ST_MISS,    10'd0},
    '{OP_LOOKUP, 32'd0,          16'd1024,   2'd0, 1'b1, ST_RANGE,   10'd0},
    '{OP_LOOKUP, 32'd0,          16'hFFFF,   2'd0, 1'b1, ST_RANGE,   10'd0},
    '{OP_MARK,   32'd0,          16'hFFFF,   2'd0, 1'b1, ST_RANGE,   10'd0},
    '{OP_MARK,   32'd0,          16'd5,      2'd3, 1'b1, ST_INVALID, 10'd0},
    '{OP_MARK,   32'd0,          16'd1,      2'd2, 1'b1, ST_OK,      10'd0},
    '{OP_ALLOC,  32'd409599,     16'd0,      2'd0, 1'b1, ST_OK,      10'd2},
    '{OP_ALLOC,  32'd1,          16'd0,      2'd0, 1'b1, ST_NOSPACE, 10'd0},
    '{OP_NOP,    32'hFFFF_FFFF,  16'hFFFF,   2'd3, 1'b1, ST_OK,      10'd0},
    '{OP_MARK,   32'd0,          16'd0,      2'd0, 1'b1, ST_OK,      10'd0},
    '{OP_LOOKUP, 32'd0,          16'd0,      2'd0, 1'b1, ST_MISS,    10'd0},
    '{OP_MARK,   32'd0,          16'd1023,   2'd1, 1'b0, ST_OK,      10'd0},
    '{OP_LOOKUP, 32'd0,          16'd1023,   2'd0, 1'b0, ST_OK,      10'd0},
    '{OP_MARK,   32'd0,          16'd2,      2'd1, 1'b0, ST_OK,      10'd0}
  };

  swap_slot_allocator_top #(
    .NUM_SLOTS(NUM_SLOTS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .byte_count_i  (byte_count_i),
    .slot_number_i (slot_number_i),
    .new_state_i   (new_state_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .granted_slot_o(granted_slot_o),
    .slot_hits_o   (slot_hits_o),
    .bytes_in_use_o(bytes_in_use_o),
    .write_total_o (write_total_o),
    .read_total_o  (read_total_o),
    .miss_total_o  (miss_total_o),
    .pages_in_use_o(pages_in_use_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // slot table model: reset state
  task automatic clear_table();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tab_state[i] = SLOT_FREE;
      tab_hits[i] = '0;
    end
    cap_reg = CAP_RESET;
    stats_on = STATS_RESET;
    used_bytes = '0;
    write_cnt = '0;
    read_cnt = '0;
    miss_cnt = '0;
    page_cnt = '0;
    hi_slot = 0;
  endtask

  // slot table model: apply one request, give its result
  task automatic apply_request(input logic [1:0] op, input logic [31:0] nbytes,
                               input logic [15:0] slot, input logic [1:0] nst,
                               output outcome_t o);
    logic [31:0] room;
    int          f;
    o = '0;
    o.status = ST_OK;
    case (op)
      OP_ALLOC: begin
        room = (cap_reg >= used_bytes) ? cap_reg - used_bytes : '0;
        if (nbytes == '0) begin
          o.status = ST_INVALID;
        end else if (room < nbytes) begin
          o.status = ST_NOSPACE;
        end else begin
          f = -1;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tab_state[i] == SLOT_FREE) begin
              f = i;
              break;
            end
          end
          if (f < 0) begin
            o.status = ST_NOSPACE;
          end else begin
            tab_state[f] = SLOT_USED;
            tab_hits[f] = '0;
            used_bytes = used_bytes + nbytes;
            if (stats_on) begin
              write_cnt = write_cnt + 1;
              page_cnt = page_cnt + 1;
            end
            o.granted = f[9:0];
            if (f > hi_slot) hi_slot = f;
          end
        end
      end
      OP_LOOKUP: begin
        if (slot >= NUM_SLOTS) begin
          o.status = ST_RANGE;
        end else if (tab_state[slot] != SLOT_USED) begin
          o.status = ST_MISS;
          if (stats_on) miss_cnt = miss_cnt + 1;
        end else begin
          if (stats_on) read_cnt = read_cnt + 1;
          tab_hits[slot] = tab_hits[slot] + 1;
          o.hits = tab_hits[slot];
        end
      end
      OP_MARK: begin
        if (slot >= NUM_SLOTS) o.status = ST_RANGE;
        else if (nst > SLOT_BAD) o.status = ST_INVALID;
        else tab_state[slot] = slot_state_e'(nst);
      end
      default: ;
    endcase
    o.bytes_used = used_bytes;
    o.writes = write_cnt;
    o.reads = read_cnt;
    o.misses = miss_cnt;
    o.pages = page_cnt;
  endtask

  // drive one item, starting and ending at a falling edge
  task automatic send_request(input logic [1:0] op, input logic [31:0] nbytes,
                              input logic [15:0] slot, input logic [1:0] nst,
                              input logic typed, input logic [2:0] t_status,
                              input logic [9:0] t_granted);
    int unsigned gap;
    outcome_t    o;
    if (sent % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    opcode_i = op;
    byte_count_i = nbytes;
    slot_number_i = slot;
    new_state_i = nst;
    do @(posedge clk_i); while (busy);
    apply_request(op, nbytes, slot, nst, o);
    if (typed) begin
      o.status = t_status;
      o.granted = t_granted;
    end
    expected_q.push_back(o);
    sent++;
    @(negedge clk_i);
  endtask

  // one configuration write, from a falling edge
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_CAPACITY) cap_reg = data;
    else stats_on = data[0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // one random item; wide allows huge and exact-fit sizes
  task automatic random_request(input int unsigned alloc_pct, input bit wide);
    int unsigned r;
    int unsigned lk_lim;
    logic [1:0]  op;
    logic [31:0] nbytes;
    logic [15:0] slot;
    logic [1:0]  nst;
    lk_lim = 4 + alloc_pct + (96 - alloc_pct) * 2 / 3;
    r = $urandom_range(0, 99);
    nbytes = $urandom();
    nst = 2'($urandom_range(0, 3));
    slot = 16'($urandom());
    if (r < 4) begin
      op = OP_NOP;
    end else if (r < 4 + alloc_pct) begin
      op = OP_ALLOC;
      r = $urandom_range(0, 99);
      if (r < 4) nbytes = '0;
      else if (wide && r < 8) nbytes = $urandom();
      else if (wide && r < 12) nbytes = (cap_reg >= used_bytes) ? cap_reg - used_bytes : '0;
      else nbytes = wide ? $urandom_range(1, 4096) : $urandom_range(1, 256);
    end else begin
      op = (r < lk_lim) ? OP_LOOKUP : OP_MARK;
      // mostly slots that have been handed out, some anywhere, some out of range
      r = $urandom_range(0, 99);
      if (r < 70) slot = 16'($urandom_range(0, hi_slot));
      else if (r < 85) slot = 16'($urandom_range(0, NUM_SLOTS - 1));
      r = $urandom_range(0, 99);
      if (r < 40) nst = SLOT_FREE;
      else if (r < 70) nst = SLOT_USED;
      else if (r < 92) nst = SLOT_BAD;
      else nst = 2'd3;
    end
    send_request(op, nbytes, slot, nst, 1'b0, ST_OK, '0);
  endtask

  // wait for idle, set both registers, then run random items
  task automatic run_phase(input logic [32:0] cap_want, input logic stats,
                           input int unsigned alloc_pct, input bit wide,
                           input bit until_full, input int unsigned count);
    int unsigned n;
    int unsigned extra;
    bit          full;
    n = 0;
    extra = 0;
    start = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    write_reg(CFG_STATS, {31'd0, stats});
    write_reg(CFG_CAPACITY, cap_want[32] ? 32'hFFFF_FFFF : cap_want[31:0]);
    while (until_full ? (extra < 40 && n < 1600) : (n < count)) begin
      random_request(alloc_pct, wide);
      n++;
      if (until_full) begin
        // keep going a while once no slot is free
        full = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) if (tab_state[i] == SLOT_FREE) full = 1'b0;
        if (full) extra++;
      end
    end
  endtask

  // result checking against the oldest expectation
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with no item pending, expected none, got status %0d",
                 $time, status_o);
        fails++;
      end else begin
        want = expected_q.pop_front();
        check_field("status", {29'd0, want.status}, {29'd0, status_o});
        check_field("granted_slot", {22'd0, want.granted}, {22'd0, granted_slot_o});
        check_field("slot_hits", want.hits, slot_hits_o);
        check_field("bytes_in_use", want.bytes_used, bytes_in_use_o);
        check_field("write_total", want.writes, write_total_o);
        check_field("read_total", want.reads, read_total_o);
        check_field("miss_total", want.misses, miss_total_o);
        check_field("pages_in_use", want.pages, pages_in_use_o);
      end
    end
  end

  // stimulus
  initial begin
    clear_table();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part under reset settings
    for (int i = 0; i < DIR_N; i++) begin
      send_request(dir_rows[i].op, dir_rows[i].nbytes, dir_rows[i].slot,
                   dir_rows[i].nst, dir_rows[i].typed, dir_rows[i].t_status,
                   dir_rows[i].t_granted);
    end

    // random phases over several capacity and stats settings
    run_phase({1'b0, used_bytes} + 33'd1000000, 1'b1, 45, 1'b1, 1'b0, 200);
    run_phase({1'b0, 32'hFFFF_FFFF}, 1'b1, 92, 1'b0, 1'b1, 0);
    run_phase(33'd0, 1'b0, 45, 1'b1, 1'b0, 200);
    run_phase({1'b0, used_bytes} + 33'd5000, 1'b1, 50, 1'b1, 1'b0, 200);
    run_phase({1'b0, 32'hFFFF_FFFF}, 1'b0, 40, 1'b1, 1'b0, 200);
    run_phase({1'b0, 32'($urandom())}, 1'($urandom_range(0, 1)), 45, 1'b1, 1'b0, 200);

    // drain
    start = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
